FILE: hdl/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Types, codes and the byte encoder shared by the UCS-2LE to UTF-8 unit.
// ----------------------------------------------------------------------------
package u2u8_pkg;

	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	typedef struct packed {
		logic [15:0] unit;
		logic [1:0]  nbytes;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} obyte_t;

	function automatic obyte_t enc_byte(input logic [15:0] unit, input logic [1:0] nbytes,
			input logic [1:0] idx);
		obyte_t r;
		r.data = unit[7:0];
		r.last = 1'b1;
		unique case (nbytes)
			LEN_TWO: begin
				if (idx == 2'd0) begin
					r.data = {3'b110, unit[10:6]};
					r.last = 1'b0;
				end else begin
					r.data = {2'b10, unit[5:0]};
				end
			end
			LEN_THREE: begin
				if (idx == 2'd0) begin
					r.data = {4'b1110, unit[15:12]};
					r.last = 1'b0;
				end else if (idx == 2'd1) begin
					r.data = {2'b10, unit[11:6]};
					r.last = 1'b0;
				end else begin
					r.data = {2'b10, unit[5:0]};
				end
			end
			default: begin
				r.data = unit[7:0];
				r.last = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/u2u8_front.sv
// ----------------------------------------------------------------------------
// u2u8_front
// Pairs input bytes into code units, classifies them and drops surrogates.
// ----------------------------------------------------------------------------
module u2u8_front import u2u8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	input  qstat_t     qstat,
	output logic       q_push,
	output entry_t     q_wdata
);

	logic       have_low_q;
	logic [7:0] low_q;
	logic       take;
	logic [15:0] unit;

	assign full = have_low_q && qstat.full;
	assign take = push && !full;
	assign unit = {in_byte, low_q};

	always_comb begin
		q_wdata.unit = unit;
		if (unit[15:7] == 9'd0) begin
			q_wdata.nbytes = LEN_ONE;
		end else if (unit[15:11] == 5'd0) begin
			q_wdata.nbytes = LEN_TWO;
		end else begin
			q_wdata.nbytes = LEN_THREE;
		end
	end

	// drop surrogate code units
	assign q_push = take && have_low_q && (unit[15:11] != 5'b11011);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_low_q <= 1'b0;
		end else if (take) begin
			have_low_q <= !have_low_q && !end_of_string;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !have_low_q) begin
			low_q <= in_byte;
		end
	end

endmodule

FILE: hdl/u2u8_queue.sv
// ----------------------------------------------------------------------------
// u2u8_queue
// Short queue of classified code units between front and back.
// ----------------------------------------------------------------------------
module u2u8_queue import u2u8_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	input  logic   pop,
	output entry_t rdata,
	output qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("push into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count out of range");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not advance");

endmodule

FILE: hdl/u2u8_back.sv
// ----------------------------------------------------------------------------
// u2u8_back
// Serialises each queued code unit into UTF-8 bytes through an output register.
// ----------------------------------------------------------------------------
module u2u8_back import u2u8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     q_rdata,
	input  qstat_t     qstat,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] utf8_byte,
	output logic       last_of_char
);

	logic       valid_q;
	logic [1:0] idx_q;
	obyte_t     nxt;
	obyte_t     out_q;
	logic       load;

	assign nxt   = enc_byte(q_rdata.unit, q_rdata.nbytes, idx_q);
	assign load  = !qstat.empty && (!valid_q || pop);
	assign q_pop = load && nxt.last;

	assign empty        = !valid_q;
	assign utf8_byte    = out_q.data;
	assign last_of_char = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= nxt.last ? 2'd0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty |-> (idx_q < q_rdata.nbytes))
		else $error("byte index beyond character length");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> (idx_q == 2'd0))
		else $error("byte index left over with empty queue");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(out_q)))
		else $error("output request lost while stalled");

endmodule

FILE: hdl/ucs2le_to_utf8_encoder_unit.sv
// ----------------------------------------------------------------------------
// ucs2le_to_utf8_encoder_unit
// UCS-2 little-endian byte stream to UTF-8 byte stream converter.
//
// channel  direction  handshake    fields
// input    in         push / full  in_byte, end_of_string
// result   out        empty / pop  utf8_byte, last_of_char
//
// A low byte is always taken; a high byte is taken while the queue has room.
// Results leave at one byte a cycle while pop is held, from the output register
// that is loaded from the queue after the high byte; a code unit gives one to
// three bytes at the back, and a pair of input bytes at most three output bytes.
// Reset clears the pairing phase, the queue and the output valid flag at once.
// Either side may stall; the queue of QUEUE_DEPTH code units decouples them.
// ----------------------------------------------------------------------------
module ucs2le_to_utf8_encoder_unit import u2u8_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] utf8_byte,
	output logic       last_of_char
);

	qstat_t qstat;
	logic   q_push;
	logic   q_pop;
	entry_t q_wdata;
	entry_t q_rdata;

	u2u8_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.qstat         (qstat),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	u2u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (qstat)
	);

	u2u8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rdata      (q_rdata),
		.qstat        (qstat),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.utf8_byte    (utf8_byte),
		.last_of_char (last_of_char)
	);

endmodule
